// ----- src/cse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int DATA_WIDTH = 16;
	localparam int IN_W       = 16;
	localparam int COS_W      = 18;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int DOT_W      = 44;
	localparam int NORM_W     = 43;
	localparam int WIDE_W     = 2 * NORM_W;
	localparam int CNT_W      = $clog2(MAX_LEN + 1);
	localparam int QUO_W      = 35;
	localparam int ROOT_W     = 18;
	localparam int SREM_W     = 21;
	localparam int STEP_W     = 6;
	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [NORM_W-1:0]       norm_a;
		logic [NORM_W-1:0]       norm_b;
		logic                    too_long;
	} sums_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} back_state_t;

endpackage
`default_nettype wire

// ----- src/cse_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cse_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [cse_pkg::IN_W-1:0]   a_elem,
	input  wire logic [cse_pkg::IN_W-1:0]   b_elem,
	input  wire logic                       last,
	input  wire logic [cse_pkg::QCNT_W-1:0] q_count,
	output logic                            push,
	output cse_pkg::sums_t                  push_entry
);
	import cse_pkg::*;

	logic                     accept;
	logic                     use_elem;
	logic signed [DATA_WIDTH-1:0] a_s, b_s;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic                     valid_s1, last_s1, use_s1, tl_s1;
	logic signed [PROD_W-1:0] ab_s1, aa_s1, bb_s1;
	logic signed [DOT_W-1:0]  dot_q, dot_nx;
	logic [NORM_W-1:0]        na_q, nb_q, na_nx, nb_nx;

	assign a_s      = a_elem[DATA_WIDTH-1:0];
	assign b_s      = b_elem[DATA_WIDTH-1:0];
	assign in_stall = (QCNT_W'(q_count) + QCNT_W'(valid_s1 & last_s1)) >= QCNT_W'(Q_DEPTH);
	assign accept   = in_valid & ~in_stall;
	assign use_elem = cnt_q < CNT_W'(MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else if (use_elem) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			use_s1  <= use_elem;
			tl_s1   <= ovf_q | ~use_elem;
			ab_s1   <= a_s * b_s;
			aa_s1   <= a_s * a_s;
			bb_s1   <= b_s * b_s;
		end
	end

	always_comb begin
		dot_nx = dot_q;
		na_nx  = na_q;
		nb_nx  = nb_q;
		if (use_s1) begin
			dot_nx = dot_q + DOT_W'(ab_s1);
			na_nx  = na_q + NORM_W'(unsigned'(aa_s1));
			nb_nx  = nb_q + NORM_W'(unsigned'(bb_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				dot_q <= dot_nx;
				na_q  <= na_nx;
				nb_q  <= nb_nx;
			end
		end
	end

	assign push                = valid_s1 & last_s1;
	assign push_entry.dot      = dot_nx;
	assign push_entry.norm_a   = na_nx;
	assign push_entry.norm_b   = nb_nx;
	assign push_entry.too_long = tl_s1;

endmodule
`default_nettype wire

// ----- src/cse_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cse_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire cse_pkg::sums_t             push_entry,
	input  wire logic                       pop,
	output logic                            not_empty,
	output cse_pkg::sums_t                  head,
	output logic [cse_pkg::QCNT_W-1:0]      count
);
	import cse_pkg::*;

	sums_t             mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;

endmodule
`default_nettype wire

// ----- src/cse_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cse_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_not_empty,
	input  wire cse_pkg::sums_t             q_head,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [cse_pkg::COS_W-1:0]       cosine,
	output logic                            zero_norm,
	output logic                            too_long
);
	import cse_pkg::*;

	back_state_t         state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic                neg_q, zn_q, tl_q;
	logic [WIDE_W-1:0]   md_q, mp_q, pd_q, pp_q, pd_nx, pp_nx;
	logic [NORM_W-1:0]   bd_q, bp_q;
	logic [WIDE_W-1:0]   rem_q;
	logic [WIDE_W:0]     rem_sh;
	logic                div_ge;
	logic [QUO_W-1:0]    quo_q, quo_nx;
	logic [2*ROOT_W-1:0] xs_q;
	logic [SREM_W-1:0]   sr_q, sr_sh, trial;
	logic                sq_ge;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W:0]     q_sum;
	logic [COS_W-1:0]    mag;
	logic                zero_in, load_out;
	logic [DOT_W-1:0]    abs_dot;

	assign zero_in = (q_head.norm_a == '0) || (q_head.norm_b == '0);
	assign abs_dot = q_head.dot[DOT_W-1] ? DOT_W'(-q_head.dot) : DOT_W'(q_head.dot);

	assign pd_nx  = pd_q + (bd_q[0] ? md_q : '0);
	assign pp_nx  = pp_q + (bp_q[0] ? mp_q : '0);
	assign rem_sh = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign div_ge = rem_sh >= {1'b0, pp_q};
	assign quo_nx = {quo_q[QUO_W-2:0], div_ge};
	assign sr_sh  = {sr_q[SREM_W-3:0], xs_q[2*ROOT_W-1 -: 2]};
	assign trial  = SREM_W'({root_q, 2'b01});
	assign sq_ge  = sr_sh >= trial;
	assign q_sum  = {1'b0, root_q} + 1'b1;
	assign mag    = COS_W'(q_sum[ROOT_W:1]);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					pop     = 1'b1;
					state_d = zero_in ? ST_OUT : ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(NORM_W - 1))
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(QUO_W - 1))
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(ROOT_W - 1))
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cosine    <= neg_q ? -mag : mag;
			zero_norm <= zn_q;
			too_long  <= tl_q;
		end
		case (state_q)
			ST_IDLE: begin
				step_q <= '0;
				neg_q  <= q_head.dot[DOT_W-1] & ~zero_in;
				zn_q   <= zero_in;
				tl_q   <= q_head.too_long;
				root_q <= '0;
				md_q   <= WIDE_W'(abs_dot[NORM_W-1:0]);
				bd_q   <= abs_dot[NORM_W-1:0];
				mp_q   <= WIDE_W'(q_head.norm_a);
				bp_q   <= q_head.norm_b;
				pd_q   <= '0;
				pp_q   <= '0;
			end
			ST_MUL: begin
				pd_q <= pd_nx;
				pp_q <= pp_nx;
				md_q <= {md_q[WIDE_W-2:0], 1'b0};
				mp_q <= {mp_q[WIDE_W-2:0], 1'b0};
				bd_q <= bd_q >> 1;
				bp_q <= bp_q >> 1;
				if (step_q == STEP_W'(NORM_W - 1)) begin
					rem_q  <= pd_nx;
					step_q <= '0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? WIDE_W'(rem_sh - {1'b0, pp_q}) : WIDE_W'(rem_sh);
				quo_q <= quo_nx;
				if (step_q == STEP_W'(QUO_W - 1)) begin
					xs_q   <= (2*ROOT_W)'(quo_nx);
					sr_q   <= '0;
					root_q <= '0;
					step_q <= '0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				xs_q   <= {xs_q[2*ROOT_W-3:0], 2'b00};
				sr_q   <= sq_ge ? sr_sh - trial : sr_sh;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/cosine_similarity_engine_unit.sv -----
// Channel | Signals                          | Transfer when
// input   | in_valid, a_elem, b_elem, last   | in_valid high and in_stall low
// output  | out_valid, cosine, zero_norm,    | out_valid high and out_stall low
//         | too_long                         |
// The front end takes one element pair per cycle unless stalled and keeps the
// running sums. The back end runs a shift-add multiply, a restoring divide
// and a digit-by-digit root per vector end. A two-entry queue holds finished
// sums, so the front end stalls only when that queue, a pending push included,
// is full. Reset clears sums, counters, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity_engine_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [cse_pkg::IN_W-1:0]    a_elem,
	input  wire logic [cse_pkg::IN_W-1:0]    b_elem,
	input  wire logic                        last,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [cse_pkg::COS_W-1:0]        cosine,
	output logic                             zero_norm,
	output logic                             too_long
);
	import cse_pkg::*;

	logic              push, pop, q_not_empty;
	sums_t             push_entry, q_head;
	logic [QCNT_W-1:0] q_count;

	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_elem     (a_elem),
		.b_elem     (b_elem),
		.last       (last),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	cse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head),
		.count      (q_count)
	);

	cse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cosine      (cosine),
		.zero_norm   (zero_norm),
		.too_long    (too_long)
	);

endmodule
`default_nettype wire

// ----- src/cse_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cse_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [cse_pkg::COS_W-1:0]   cosine,
	input wire logic                        zero_norm
);
	import cse_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cosine) && $stable(zero_norm))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> cosine == '0)
		else $error("zero norm with nonzero cosine");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(cosine) >= -65536) && ($signed(cosine) <= 65536))
		else $error("cosine out of range");

endmodule

bind cosine_similarity_engine_unit cse_checker u_cse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cosine    (cosine),
	.zero_norm (zero_norm)
);
`default_nettype wire
